FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the grid point snap RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define GPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked check that also holds across reset.
`define GPS_ASSERT_NR(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/gps_pkg.sv
// ----------------------------------------------------------------------------
// gps_pkg
// Shared types, constants and helper functions of the grid point snap unit.
// ----------------------------------------------------------------------------
package gps_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int PT_W  = 15;   // input coordinate width
    localparam int SP_W  = 11;   // grid spacing width
    localparam int IDX_W = 18;   // column and row index width
    localparam int VTX_W = 20;   // exact vertex coordinate width
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [SP_W-1:0] SP_RESET = SP_W'(8);

    // Register map: index taken from paddr[2].
    localparam logic REG_GRID_TYPE    = 1'b0;
    localparam logic REG_GRID_SPACING = 1'b1;

    localparam logic [63:0] SQRT3_HALF_Q32 = 64'd3719550787;

    // sqrt(3)/2 rounded half up to f fraction bits.
    function automatic logic [31:0] sqrt3_half_q(input int f);
        logic [63:0] v;
        v = (SQRT3_HALF_Q32 + (64'd1 << (31 - f))) >> (32 - f);
        return v[31:0];
    endfunction

    typedef enum logic [4:0] {
        S_IDLE, S_RDX, S_RWX, S_RX, S_RDY, S_RWY, S_RY, S_RFIN,
        S_NDIV, S_NWAIT, S_NLO, S_MDIV, S_MWAIT, S_MUL, S_SEL, S_SQR,
        S_SUM, S_IFIN
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_DIV_RX, OP_DIV_RY, OP_RX, OP_RY, OP_RFIN,
        OP_DIV_N, OP_NLO, OP_DIV_M, OP_MUL, OP_SEL, OP_SQR, OP_SUM, OP_IFIN
    } t_op;

    typedef struct packed {
        t_op  op;
        logic div_start;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic div_busy;
        logic col;
    } t_dp_stat;

endpackage

FILE: rtl/gps_div.sv
// ----------------------------------------------------------------------------
// gps_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gps_div #(
    parameter int NW  = 31,
    parameter int DVW = 27
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [NW-1:0]  i_dividend,
    input  logic [DVW-1:0] i_divisor,
    output logic           o_busy,
    output logic           o_done,
    output logic [NW-1:0]  o_quot,
    output logic [DVW-1:0] o_rem
);
    localparam int CW = $clog2(NW + 1);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quot;
    logic [DVW-1:0] r_rem, r_div;
    logic [DVW:0]  w_trial, w_diff;
    logic          w_ge;

    assign w_trial = {r_rem, r_quot[NW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[NW-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[DVW-1:0] : w_trial[DVW-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule

FILE: rtl/gps_dp.sv
// ----------------------------------------------------------------------------
// gps_dp
// Snap datapath: operand registers, shared divider, multipliers, held point.
// ----------------------------------------------------------------------------
module gps_dp #(
    parameter int COORD_BITS = gps_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = gps_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gps_pkg::t_dp_cmd              i_cmd,
    input  logic signed [gps_pkg::PT_W-1:0] i_point_x,
    input  logic signed [gps_pkg::PT_W-1:0] i_point_y,
    input  logic                          i_constrain,
    input  logic [gps_pkg::SP_W-1:0]      i_spacing,
    output gps_pkg::t_dp_stat             o_stat,
    output logic signed [COORD_BITS-1:0]  o_snap_x,
    output logic signed [COORD_BITS-1:0]  o_snap_y
);
    import gps_pkg::*;

    localparam int NW  = PT_W + FRAC_BITS;
    localparam int NV  = NW + 1;
    localparam int DVW = SP_W + FRAC_BITS;
    localparam int MRW = IDX_W + SP_W + 1;
    localparam int LW  = MRW + 2;
    localparam int NHW = IDX_W + DVW + 1;
    localparam int SQW = 2 * (VTX_W + 1);
    localparam int DSW = SQW + 1;
    localparam logic [FRAC_BITS-1:0] KF = FRAC_BITS'(sqrt3_half_q(FRAC_BITS));

    // Item and configuration derived operands.
    logic signed [PT_W-1:0]  r_x, r_y;
    logic                    r_cons;
    logic [DVW-1:0]          r_hq;
    logic [SP_W-1:0]         w_s;

    // Divider interface.
    logic signed [NV-1:0]    w_dv;
    logic [DVW-1:0]          w_dsr;
    logic [NW-1:0]           w_mag, w_quot;
    logic [DVW-1:0]          w_rem;
    logic                    r_dneg;
    logic signed [NV-1:0]    w_q;
    logic signed [DVW:0]     w_r;

    // Rectangular path.
    logic                    w_up;
    logic signed [IDX_W-1:0] w_qa;
    logic signed [IDX_W+SP_W:0] w_rp;
    logic signed [COORD_BITS-1:0] r_gx, r_gy, r_hx, r_hy;
    logic signed [COORD_BITS:0] w_ex, w_ey;
    logic [COORD_BITS:0]     w_ax, w_ay;

    // Isometric path.
    logic signed [IDX_W-1:0] r_n, w_m;
    logic                    r_col;
    logic signed [SP_W+1:0]  w_or;
    logic signed [PT_W:0]    w_2y;
    logic signed [IDX_W-1:0] w_mnum;
    logic signed [MRW-1:0]   r_mr;
    logic signed [NHW-1:0]   r_nh, w_nhb, w_nhr;
    logic signed [LW-1:0]    w_lo2, w_hi2, w_t2y, w_ea, w_eb, w_sel, w_selr;
    logic [LW-1:0]           w_aa, w_ab;
    logic signed [VTX_W-1:0] r_vx, r_vy, r_x0, r_y0;
    logic signed [VTX_W:0]   w_dx, w_dy;
    logic signed [SQW-1:0]   r_dx2, r_dy2;
    logic signed [DSW-1:0]   w_d, r_d0, r_d1;

    logic signed [COORD_BITS-1:0] r_ox, r_oy;
    logic                    w_busy, w_done;

    assign w_s = (i_spacing == '0) ? SP_W'(1) : i_spacing;

    // Odd columns are offset by half a spacing; sign follows C remainder.
    assign w_or = r_n[0] ? (r_n[IDX_W-1] ? -$signed({2'b00, w_s}) : $signed({2'b00, w_s}))
                         : '0;
    assign w_2y   = $signed({r_y, 1'b0});
    assign w_mnum = IDX_W'(w_2y) - IDX_W'(w_or);

    always_comb begin
        case (i_cmd.op)
            OP_DIV_RX: begin
                w_dv  = NV'(r_x);
                w_dsr = DVW'(w_s);
            end
            OP_DIV_RY: begin
                w_dv  = NV'(r_y);
                w_dsr = DVW'(w_s);
            end
            OP_DIV_N: begin
                w_dv  = NV'($signed({r_x, {FRAC_BITS{1'b0}}}));
                w_dsr = r_hq;
            end
            OP_DIV_M: begin
                w_dv  = NV'(w_mnum);
                w_dsr = DVW'({w_s, 1'b0});
            end
            default: begin
                w_dv  = '0;
                w_dsr = r_hq;
            end
        endcase
    end

    assign w_mag = w_dv[NV-1] ? NW'(-w_dv) : NW'(w_dv);

    gps_div #(.NW(NW), .DVW(DVW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_mag),
        .i_divisor  (w_dsr),
        .o_busy     (w_busy),
        .o_done     (w_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // Truncating division: quotient and remainder carry the dividend's sign.
    assign w_q = r_dneg ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});
    assign w_r = r_dneg ? -$signed({1'b0, w_rem}) : $signed({1'b0, w_rem});

    assign w_up = (w_r > $signed((DVW + 1)'(w_s >> 1)));
    assign w_qa = IDX_W'(w_q) + {{(IDX_W - 1){1'b0}}, w_up};
    assign w_rp = w_qa * $signed({1'b0, w_s});

    assign w_ex = (COORD_BITS + 1)'(r_gx) - (COORD_BITS + 1)'(r_hx);
    assign w_ey = (COORD_BITS + 1)'(r_gy) - (COORD_BITS + 1)'(r_hy);
    assign w_ax = w_ex[COORD_BITS] ? unsigned'(-w_ex) : unsigned'(w_ex);
    assign w_ay = w_ey[COORD_BITS] ? unsigned'(-w_ey) : unsigned'(w_ey);

    assign w_m   = IDX_W'(w_q);
    assign w_t2y = LW'(w_2y);
    assign w_lo2 = (LW'(r_mr) <<< 1) + LW'(w_or);
    assign w_hi2 = w_lo2 + LW'($signed({2'b00, w_s, 1'b0}));
    assign w_ea  = w_lo2 - w_t2y;
    assign w_eb  = w_hi2 - w_t2y;
    assign w_aa  = w_ea[LW-1] ? unsigned'(-w_ea) : unsigned'(w_ea);
    assign w_ab  = w_eb[LW-1] ? unsigned'(-w_eb) : unsigned'(w_eb);
    assign w_sel = (w_aa < w_ab) ? w_lo2 : w_hi2;
    assign w_selr = w_sel + LW'($signed({1'b0, w_sel[LW-1]}));

    assign w_nhb = r_nh[NHW-1] ? $signed(NHW'({FRAC_BITS{1'b1}})) : '0;
    assign w_nhr = r_nh + w_nhb;

    assign w_dx = (VTX_W + 1)'(r_x) - (VTX_W + 1)'(r_vx);
    assign w_dy = (VTX_W + 1)'(r_y) - (VTX_W + 1)'(r_vy);
    assign w_d  = DSW'(r_dx2) + DSW'(r_dy2);

    // Control state and the held point.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hx  <= '0;
            r_hy  <= '0;
            r_col <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_RFIN: begin
                    if (!r_cons) begin
                        r_hx <= r_gx;
                        r_hy <= r_gy;
                    end
                end
                OP_NLO:  r_col <= 1'b0;
                OP_SUM:  r_col <= 1'b1;
                default: ;
            endcase
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dneg <= w_dv[NV-1];
        end
        case (i_cmd.op)
            OP_LOAD: begin
                r_x    <= i_point_x;
                r_y    <= i_point_y;
                r_cons <= i_constrain;
                r_hq   <= DVW'(w_s) * DVW'(KF);
            end
            OP_RX: r_gx <= COORD_BITS'(w_rp);
            OP_RY: r_gy <= COORD_BITS'(w_rp);
            OP_RFIN: begin
                if (r_cons && (w_ax < w_ay)) begin
                    r_ox <= r_hx;
                    r_oy <= r_gy;
                end else if (r_cons) begin
                    r_ox <= r_gx;
                    r_oy <= r_hy;
                end else begin
                    r_ox <= r_gx;
                    r_oy <= r_gy;
                end
            end
            OP_NLO: r_n <= IDX_W'(w_q);
            OP_MUL: begin
                r_mr <= w_m * $signed({1'b0, w_s});
                r_nh <= r_n * $signed({1'b0, r_hq});
            end
            OP_SEL: begin
                r_vy <= VTX_W'(w_selr >>> 1);
                r_vx <= VTX_W'(w_nhr >>> FRAC_BITS);
            end
            OP_SQR: begin
                r_dx2 <= w_dx * w_dx;
                r_dy2 <= w_dy * w_dy;
            end
            OP_SUM: begin
                if (!r_col) begin
                    r_d0 <= w_d;
                    r_x0 <= r_vx;
                    r_y0 <= r_vy;
                    r_n  <= r_n + IDX_W'(1);
                end else begin
                    r_d1 <= w_d;
                end
            end
            OP_IFIN: begin
                // A distance tie goes to the upper column.
                if (r_d0 < r_d1) begin
                    r_ox <= COORD_BITS'(r_x0);
                    r_oy <= COORD_BITS'(r_y0);
                end else begin
                    r_ox <= COORD_BITS'(r_vx);
                    r_oy <= COORD_BITS'(r_vy);
                end
            end
            default: ;
        endcase
    end

    assign o_stat.div_done = w_done;
    assign o_stat.div_busy = w_busy;
    assign o_stat.col      = r_col;
    assign o_snap_x        = r_ox;
    assign o_snap_y        = r_oy;
endmodule

FILE: rtl/gps_ctrl.sv
// ----------------------------------------------------------------------------
// gps_ctrl
// Sequencer of the snap unit: handshakes and datapath command generation.
// ----------------------------------------------------------------------------
module gps_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  logic               i_grid_type,
    input  gps_pkg::t_dp_stat  i_stat,
    output gps_pkg::t_dp_cmd   o_cmd
);
    import gps_pkg::*;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    logic    w_out_free;
    t_dp_cmd w_cmd;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = i_grid_type ? S_NDIV : S_RDX;
            S_RDX:   n_state = S_RWX;
            S_RWX:   if (i_stat.div_done) n_state = S_RX;
            S_RX:    n_state = S_RDY;
            S_RDY:   n_state = S_RWY;
            S_RWY:   if (i_stat.div_done) n_state = S_RY;
            S_RY:    n_state = S_RFIN;
            S_RFIN:  if (w_out_free) n_state = S_IDLE;
            S_NDIV:  n_state = S_NWAIT;
            S_NWAIT: if (i_stat.div_done) n_state = S_NLO;
            S_NLO:   n_state = S_MDIV;
            S_MDIV:  n_state = S_MWAIT;
            S_MWAIT: if (i_stat.div_done) n_state = S_MUL;
            S_MUL:   n_state = S_SEL;
            S_SEL:   n_state = S_SQR;
            S_SQR:   n_state = S_SUM;
            S_SUM:   n_state = i_stat.col ? S_IFIN : S_MDIV;
            S_IFIN:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_cmd.op        = OP_NONE;
        w_cmd.div_start = 1'b0;
        case (r_state)
            S_IDLE:  if (i_in_valid) w_cmd.op = OP_LOAD;
            S_RDX: begin
                w_cmd.op        = OP_DIV_RX;
                w_cmd.div_start = 1'b1;
            end
            S_RX:    w_cmd.op = OP_RX;
            S_RDY: begin
                w_cmd.op        = OP_DIV_RY;
                w_cmd.div_start = 1'b1;
            end
            S_RY:    w_cmd.op = OP_RY;
            S_RFIN:  if (w_out_free) w_cmd.op = OP_RFIN;
            S_NDIV: begin
                w_cmd.op        = OP_DIV_N;
                w_cmd.div_start = 1'b1;
            end
            S_NLO:   w_cmd.op = OP_NLO;
            S_MDIV: begin
                w_cmd.op        = OP_DIV_M;
                w_cmd.div_start = 1'b1;
            end
            S_MUL:   w_cmd.op = OP_MUL;
            S_SEL:   w_cmd.op = OP_SEL;
            S_SQR:   w_cmd.op = OP_SQR;
            S_SUM:   w_cmd.op = OP_SUM;
            S_IFIN:  if (w_out_free) w_cmd.op = OP_IFIN;
            default: w_cmd.op = OP_NONE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (w_cmd.op == OP_RFIN || w_cmd.op == OP_IFIN) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

`include "assert_macros.svh"

    `GPS_ASSERT(a_accept_busy, (i_in_valid && !o_in_stall) |=> o_in_stall, "accepted beat did not start work")
    `GPS_ASSERT(a_fin_free, (w_cmd.op == OP_RFIN || w_cmd.op == OP_IFIN) |-> w_out_free, "result overwrote a waiting beat")
    `GPS_ASSERT(a_div_idle, w_cmd.div_start |-> !i_stat.div_busy, "divider restarted while busy")
    `GPS_ASSERT_NR(a_rst_clear, !i_rst_n |=> !r_out_valid, "output valid survived reset")
endmodule

FILE: rtl/grid_point_snap_unit.sv
// ----------------------------------------------------------------------------
// grid_point_snap_unit
// Snaps a pointer position to the nearest rectangular or isometric vertex.
// ----------------------------------------------------------------------------
// Usage: a point beat (i_point_x, i_point_y, i_constrain) is taken when
// i_in_valid is high and o_in_stall is low. One snapped vertex beat
// (o_snap_x, o_snap_y) comes out per point, valid while o_out_valid is high
// and taken on a cycle where i_out_stall is low.
// The block works on one point at a time. All divisions by the spacing and
// by the isometric column pitch run through one restoring divider that
// produces one quotient bit per cycle. A rectangular point uses two
// divisions and an isometric point uses three.
// The result sits in an output register, so a stalled receiver holds the
// beat there; the next point may be accepted and worked on meanwhile, and
// its finish step waits until the register has been emptied.
// Reset clears the held point to zero, sets a rectangular grid of spacing
// eight, and drops o_out_valid; pready is always high. The user must write
// configuration through the APB port only while the block is idle (unenforced).
// ----------------------------------------------------------------------------
module grid_point_snap_unit #(
    parameter int COORD_BITS = gps_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = gps_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Point channel.
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [gps_pkg::PT_W-1:0]   i_point_x,
    input  logic signed [gps_pkg::PT_W-1:0]   i_point_y,
    input  logic                              i_constrain,
    // Vertex channel.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [COORD_BITS-1:0]      o_snap_x,
    output logic signed [COORD_BITS-1:0]      o_snap_y,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gps_pkg::ADDR_W-1:0]        paddr,
    input  logic [gps_pkg::DATA_W-1:0]        pwdata,
    output logic [gps_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);
    import gps_pkg::*;

    logic            r_grid_type;
    logic [SP_W-1:0] r_grid_spacing;
    logic            w_cfg_wr;
    t_dp_cmd         w_cmd;
    t_dp_stat        w_stat;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    // Registers sit at byte addresses 0 and 4; bit 2 selects the register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_type    <= 1'b0;
            r_grid_spacing <= SP_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_GRID_TYPE) begin
                r_grid_type <= pwdata[0];
            end else begin
                r_grid_spacing <= pwdata[SP_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_GRID_SPACING) begin
            prdata = DATA_W'(r_grid_spacing);
        end else begin
            prdata = DATA_W'(r_grid_type);
        end
    end

    // The sequencer issues one command per cycle; the datapath reports
    // divider progress and which isometric column is being evaluated.
    gps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_grid_type (r_grid_type),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    gps_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_constrain (i_constrain),
        .i_spacing   (r_grid_spacing),
        .o_stat      (w_stat),
        .o_snap_x    (o_snap_x),
        .o_snap_y    (o_snap_y)
    );
endmodule
